>>> src/sssp_pkg.sv
// ----------------------------------------------------------------------------
// sssp_pkg: shared types and constants of the shortest path unit
// Sizes, request and status codes, and the packed transaction and table
// entry formats used by the sequencer, the tables and the arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sssp_pkg;

    localparam int MAX_NODES   = 64;
    localparam int MAX_EDGES   = 512;
    localparam int WEIGHT_BITS = 16;

    localparam int NODE_W     = 6;
    localparam int NODE_CNT_W = 7;
    localparam int EDGE_AW    = $clog2(MAX_EDGES);
    localparam int EDGE_CNT_W = $clog2(MAX_EDGES + 1);
    localparam int DIST_W     = 22;

    localparam logic [DIST_W-1:0]     DIST_MAX  = {DIST_W{1'b1}};
    localparam logic [NODE_CNT_W-1:0] NODES_CAP = NODE_CNT_W'(MAX_NODES);
    localparam logic [EDGE_CNT_W-1:0] EDGES_CAP = EDGE_CNT_W'(MAX_EDGES);

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_RUN   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]             req_type;
        logic [NODE_W-1:0]      edge_from;
        logic [NODE_W-1:0]      edge_to;
        logic [15:0]            edge_weight;
        logic [NODE_W-1:0]      start_node;
    } req_t;

    typedef struct packed {
        logic [NODE_W-1:0]      node_index;
        logic [DIST_W-1:0]      distance;
        logic                   reachable;
        logic [1:0]             status;
        logic                   last;
    } rsp_t;

    typedef struct packed {
        logic [NODE_W-1:0]      from;
        logic [NODE_W-1:0]      to;
        logic [WEIGHT_BITS-1:0] weight;
    } edge_ent_t;

    typedef struct packed {
        logic [DIST_W-1:0]      distance;
        logic                   settled;
        logic                   reached;
    } node_ent_t;

endpackage

`default_nettype wire

>>> src/sssp_edge_mem.sv
// ----------------------------------------------------------------------------
// sssp_edge_mem: edge table storage
// One write port and one registered read port over the stored edges.
// ----------------------------------------------------------------------------
`default_nettype none

module sssp_edge_mem (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [sssp_pkg::EDGE_AW-1:0] wr_addr,
    input  wire sssp_pkg::edge_ent_t         wr_data,
    input  wire logic [sssp_pkg::EDGE_AW-1:0] rd_addr,
    output sssp_pkg::edge_ent_t              rd_data
);
    import sssp_pkg::*;

    edge_ent_t mem [MAX_EDGES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> src/sssp_node_mem.sv
// ----------------------------------------------------------------------------
// sssp_node_mem: per-node distance and flag storage
// Holds distance, settled and reached for each node; registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sssp_node_mem (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [sssp_pkg::NODE_W-1:0] wr_addr,
    input  wire sssp_pkg::node_ent_t        wr_data,
    input  wire logic [sssp_pkg::NODE_W-1:0] rd_addr,
    output sssp_pkg::node_ent_t             rd_data
);
    import sssp_pkg::*;

    node_ent_t mem [MAX_NODES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> src/sssp_alu.sv
// ----------------------------------------------------------------------------
// sssp_alu: shared saturating add and compare
// Adds a weight to a distance with saturation and compares the sum
// against a bound. Used both for minimum selection and for relaxation.
// ----------------------------------------------------------------------------
`default_nettype none

module sssp_alu (
    input  wire logic [sssp_pkg::DIST_W-1:0]      base,
    input  wire logic [sssp_pkg::WEIGHT_BITS-1:0] addend,
    input  wire logic [sssp_pkg::DIST_W-1:0]      bound,
    output logic      [sssp_pkg::DIST_W-1:0]      sum,
    output logic                                  less
);
    import sssp_pkg::*;

    logic [DIST_W:0] raw;

    always_comb
    begin
        raw  = {1'b0, base} + (DIST_W + 1)'(addend);
        sum  = raw[DIST_W] ? DIST_MAX : raw[DIST_W-1:0];
        less = (sum < bound);
    end

endmodule

`default_nettype wire

>>> src/single_source_shortest_paths_unit.sv
// ----------------------------------------------------------------------------
// single_source_shortest_paths_unit: shortest distances over an edge table
// Add edge, clear and rejected run requests answer with one status result in
// the cycle after acceptance and leave busy low, so they can come every cycle.
// A run holds busy through initialization of the node table, then for each
// settled node a minimum scan over the node table, a settle step and, with
// stored edges, a scan over every stored edge that relaxes the edges leaving
// the node; a last scan and settle step find nothing left, then the readout
// emits one result per node in use, paced by the node table's single read port.
// Reset sets the edge count to zero and the node count to 64; the tables
// themselves are not cleared. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module single_source_shortest_paths_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire sssp_pkg::req_t                request,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sssp_pkg::NODE_CNT_W-1:0] cfg_data,
    output logic                               strobe,
    output sssp_pkg::rsp_t                     result
);
    import sssp_pkg::*;

    // The sequencer walks through initialization, a minimum scan over the
    // node table, settling the chosen node, an edge scan that relaxes the
    // edges leaving it, and finally a readout of every node in order.
    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_INIT   = 10'b00_0000_0010,
        ST_S_RD   = 10'b00_0000_0100,
        ST_S_CHK  = 10'b00_0000_1000,
        ST_SETTLE = 10'b00_0001_0000,
        ST_E_RD   = 10'b00_0010_0000,
        ST_E_CHK  = 10'b00_0100_0000,
        ST_E_REL  = 10'b00_1000_0000,
        ST_O_RD   = 10'b01_0000_0000,
        ST_O_EMIT = 10'b10_0000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [NODE_CNT_W-1:0] node_count_reg;
    logic [EDGE_CNT_W-1:0] edge_total_reg, edge_total_next;
    logic [NODE_W-1:0]     idx_reg, idx_next;
    logic [EDGE_AW-1:0]    edge_idx_reg, edge_idx_next;
    logic [NODE_W-1:0]     start_reg, start_next;
    logic                  best_vld_reg, best_vld_next;
    logic [NODE_W-1:0]     best_idx_reg, best_idx_next;
    logic [DIST_W-1:0]     best_dist_reg, best_dist_next;
    logic [NODE_W-1:0]     to_reg, to_next;
    logic [WEIGHT_BITS-1:0] w_reg, w_next;
    logic                  strobe_reg, strobe_next;
    rsp_t                  result_reg, result_next;

    logic [NODE_CNT_W-1:0] cnt;
    logic                  idx_is_last;
    logic                  edge_is_last;
    logic                  accept;

    logic                  edge_we;
    edge_ent_t             edge_wdata;
    logic [EDGE_AW-1:0]    edge_raddr;
    edge_ent_t             edge_rd;

    logic                  node_we;
    logic [NODE_W-1:0]     node_waddr;
    node_ent_t             node_wdata;
    logic [NODE_W-1:0]     node_raddr;
    node_ent_t             node_rd;

    logic [DIST_W-1:0]      alu_base;
    logic [WEIGHT_BITS-1:0] alu_addend;
    logic [DIST_W-1:0]      alu_bound;
    logic [DIST_W-1:0]      alu_sum;
    logic                   alu_less;

    logic                  edge_match;
    logic                  cand_ok;

    sssp_edge_mem u_edge_mem (
        .clk     (clk),
        .wr_en   (edge_we),
        .wr_addr (edge_total_reg[EDGE_AW-1:0]),
        .wr_data (edge_wdata),
        .rd_addr (edge_raddr),
        .rd_data (edge_rd)
    );

    sssp_node_mem u_node_mem (
        .clk     (clk),
        .wr_en   (node_we),
        .wr_addr (node_waddr),
        .wr_data (node_wdata),
        .rd_addr (node_raddr),
        .rd_data (node_rd)
    );

    sssp_alu u_alu (
        .base   (alu_base),
        .addend (alu_addend),
        .bound  (alu_bound),
        .sum    (alu_sum),
        .less   (alu_less)
    );

    // The effective node count saturates at the table size.
    assign cnt          = (node_count_reg > NODES_CAP) ? NODES_CAP : node_count_reg;
    assign idx_is_last  = ({1'b0, idx_reg} == (cnt - 1'b1));
    assign edge_is_last = (({1'b0, edge_idx_reg} + 1'b1) >= edge_total_reg);
    assign accept       = start && (state_reg == ST_IDLE);

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign strobe    = strobe_reg;
    assign result    = result_reg;

    // An edge leaving the settled node counts only if its target is in use.
    assign edge_match = (edge_rd.from == best_idx_reg) && ({1'b0, edge_rd.to} < cnt);

    // The shared unit compares a scanned distance against the best one while
    // scanning, and forms and checks the relaxed cost while relaxing.
    always_comb
    begin
        if (state_reg == ST_E_REL)
        begin
            alu_base   = best_dist_reg;
            alu_addend = w_reg;
            alu_bound  = node_rd.distance;
        end
        else
        begin
            alu_base   = node_rd.distance;
            alu_addend = '0;
            alu_bound  = best_dist_reg;
        end
    end

    assign cand_ok = node_rd.reached && !node_rd.settled && (!best_vld_reg || alu_less);

    always_comb
    begin
        state_next      = state_reg;
        edge_total_next = edge_total_reg;
        idx_next        = idx_reg;
        edge_idx_next   = edge_idx_reg;
        start_next      = start_reg;
        best_vld_next   = best_vld_reg;
        best_idx_next   = best_idx_reg;
        best_dist_next  = best_dist_reg;
        to_next         = to_reg;
        w_next          = w_reg;
        strobe_next     = 1'b0;
        result_next     = result_reg;

        edge_we         = 1'b0;
        edge_wdata      = '{from: request.edge_from, to: request.edge_to,
                            weight: request.edge_weight[WEIGHT_BITS-1:0]};
        edge_raddr      = edge_idx_reg;

        node_we         = 1'b0;
        node_waddr      = idx_reg;
        node_wdata      = '{distance: '0, settled: 1'b0, reached: (idx_reg == start_reg)};
        node_raddr      = idx_reg + 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    result_next = '{node_index: '0, distance: '0, reachable: 1'b0,
                                    status: STAT_OK, last: 1'b1};
                    priority if (request.req_type == REQ_ADD)
                    begin
                        strobe_next = 1'b1;
                        if (({1'b0, request.edge_from} >= cnt) ||
                            ({1'b0, request.edge_to} >= cnt))
                        begin
                            result_next.status = STAT_RANGE;
                        end
                        else if (edge_total_reg >= EDGES_CAP)
                        begin
                            result_next.status = STAT_FULL;
                        end
                        else
                        begin
                            edge_we         = 1'b1;
                            edge_total_next = edge_total_reg + 1'b1;
                        end
                    end
                    else if (request.req_type == REQ_CLEAR)
                    begin
                        strobe_next     = 1'b1;
                        edge_total_next = '0;
                    end
                    else if (request.req_type == REQ_RUN)
                    begin
                        if ({1'b0, request.start_node} >= cnt)
                        begin
                            strobe_next        = 1'b1;
                            result_next.status = STAT_RANGE;
                        end
                        else
                        begin
                            start_next = request.start_node;
                            idx_next   = '0;
                            state_next = ST_INIT;
                        end
                    end
                    else
                    begin
                        // The unused request code is ignored.
                        strobe_next = 1'b0;
                    end
                end
            end

            ST_INIT:
            begin
                node_we  = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_is_last)
                begin
                    state_next = ST_S_RD;
                end
            end

            ST_S_RD:
            begin
                node_raddr    = '0;
                idx_next      = '0;
                best_vld_next = 1'b0;
                state_next    = ST_S_CHK;
            end

            ST_S_CHK:
            begin
                if (cand_ok)
                begin
                    best_vld_next  = 1'b1;
                    best_idx_next  = idx_reg;
                    best_dist_next = node_rd.distance;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_is_last)
                begin
                    state_next = ST_SETTLE;
                end
            end

            ST_SETTLE:
            begin
                if (!best_vld_reg)
                begin
                    state_next = ST_O_RD;
                end
                else
                begin
                    node_we       = 1'b1;
                    node_waddr    = best_idx_reg;
                    node_wdata    = '{distance: best_dist_reg, settled: 1'b1, reached: 1'b1};
                    edge_idx_next = '0;
                    state_next    = (edge_total_reg == '0) ? ST_S_RD : ST_E_RD;
                end
            end

            ST_E_RD:
            begin
                state_next = ST_E_CHK;
            end

            ST_E_CHK:
            begin
                if (edge_match)
                begin
                    node_raddr = edge_rd.to;
                    to_next    = edge_rd.to;
                    w_next     = edge_rd.weight;
                    state_next = ST_E_REL;
                end
                else if (edge_is_last)
                begin
                    state_next = ST_S_RD;
                end
                else
                begin
                    // Keep streaming: the next edge is read while this one
                    // is dropped.
                    edge_idx_next = edge_idx_reg + 1'b1;
                    edge_raddr    = edge_idx_reg + 1'b1;
                end
            end

            ST_E_REL:
            begin
                if (!node_rd.reached || alu_less)
                begin
                    node_we    = 1'b1;
                    node_waddr = to_reg;
                    node_wdata = '{distance: alu_sum, settled: node_rd.settled,
                                   reached: 1'b1};
                end
                if (edge_is_last)
                begin
                    state_next = ST_S_RD;
                end
                else
                begin
                    edge_idx_next = edge_idx_reg + 1'b1;
                    state_next    = ST_E_RD;
                end
            end

            ST_O_RD:
            begin
                node_raddr = '0;
                idx_next   = '0;
                state_next = ST_O_EMIT;
            end

            ST_O_EMIT:
            begin
                strobe_next = 1'b1;
                result_next = '{node_index: idx_reg,
                                distance: node_rd.reached ? node_rd.distance : '0,
                                reachable: node_rd.reached,
                                status: STAT_OK,
                                last: idx_is_last};
                idx_next = idx_reg + 1'b1;
                if (idx_is_last)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= NODES_CAP;
            edge_total_reg <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            strobe_reg     <= strobe_next;
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= cfg_data;
            end
        end
    end

    // Datapath registers carry no reset; the sequencer writes them before use.
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        edge_idx_reg  <= edge_idx_next;
        start_reg     <= start_next;
        best_vld_reg  <= best_vld_next;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        to_reg        <= to_next;
        w_reg         <= w_next;
        result_reg    <= result_next;
    end

endmodule

`default_nettype wire
